// File: src/whp_pkg.sv
`default_nettype none

package whp_pkg;

  localparam int unsigned ResultWidth = 112;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [15:0] FmtPcm    = 16'h0001;
  localparam logic [31:0] FmtMinLen = 32'd16;
  localparam logic [31:0] GapBytes  = 32'd6;

  typedef enum logic [3:0] {
    PhRiff,
    PhRsize,
    PhWave,
    PhFmtTag,
    PhFlen,
    PhFormat,
    PhChan,
    PhRate,
    PhGap,
    PhBits,
    PhFskip,
    PhCtag,
    PhDsize,
    PhOsize,
    PhCskip,
    PhDone
  } phase_e;

  typedef enum logic [2:0] {
    StParsing  = 3'd0,
    StData     = 3'd1,
    StBadTag   = 3'd2,
    StPcm8     = 3'd3,
    StTrunc    = 3'd4,
    StShortFmt = 3'd5
  } status_e;

  // first listed member sits in the top bits
  typedef struct packed {
    logic [31:0] data_bytes;
    logic [12:0] sample_bytes;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] format_code;
    status_e     status;
  } result_t;

endpackage

`default_nettype wire

// File: src/whp_parse_core.sv
`default_nettype none

module whp_parse_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [7:0]      stream_byte_i,
  input  wire logic            restart_i,
  input  wire logic            stream_end_i,
  output whp_pkg::result_t     result_o
);
  import whp_pkg::*;

  phase_e      ph_q, ph_d, ph_c;
  logic [1:0]  bif_q, bif_d, bif_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [31:0] shift_q, shift_d, shift_c;
  logic [15:0] fmt_q, fmt_d, fmt_c;
  logic [15:0] chan_q, chan_d, chan_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [12:0] sbytes_q, sbytes_d, sbytes_c;
  logic [31:0] flen_q, flen_d, flen_c;
  logic [31:0] dlen_q, dlen_d, dlen_c;
  status_e     st_q, st_d, st_c;

  logic [31:0] gword;
  logic [31:0] skip_dec;
  logic [31:0] flen_rest;
  logic        done2, done4;
  logic [12:0] bits_sh;

  // restart clears state ahead of this beat
  always_comb begin
    ph_c     = restart_i ? PhRiff    : ph_q;
    bif_c    = restart_i ? 2'd0      : bif_q;
    skip_c   = restart_i ? 32'd0     : skip_q;
    shift_c  = restart_i ? 32'd0     : shift_q;
    fmt_c    = restart_i ? 16'd0     : fmt_q;
    chan_c   = restart_i ? 16'd0     : chan_q;
    rate_c   = restart_i ? 32'd0     : rate_q;
    sbytes_c = restart_i ? 13'd0     : sbytes_q;
    flen_c   = restart_i ? 32'd0     : flen_q;
    dlen_c   = restart_i ? 32'd0     : dlen_q;
    st_c     = restart_i ? StParsing : st_q;
  end

  // little-endian field gather
  always_comb begin
    unique case (bif_c)
      2'd0: gword = {24'd0, stream_byte_i};
      2'd1: gword = {shift_c[31:16], stream_byte_i, shift_c[7:0]};
      2'd2: gword = {shift_c[31:24], stream_byte_i, shift_c[15:0]};
      2'd3: gword = {stream_byte_i, shift_c[23:0]};
      default: gword = {24'd0, stream_byte_i};
    endcase
  end

  assign done2     = (bif_c != 2'd0);
  assign done4     = (bif_c == 2'd3);
  assign skip_dec  = skip_c - 32'd1;
  assign flen_rest = flen_c - FmtMinLen;
  assign bits_sh   = gword[15:3];

  always_comb begin
    ph_d     = ph_c;
    bif_d    = bif_c;
    skip_d   = skip_c;
    shift_d  = shift_c;
    fmt_d    = fmt_c;
    chan_d   = chan_c;
    rate_d   = rate_c;
    sbytes_d = sbytes_c;
    flen_d   = flen_c;
    dlen_d   = dlen_c;
    st_d     = st_c;
    if (st_c == StParsing) begin
      if (stream_end_i) begin
        st_d = StTrunc;
        ph_d = PhDone;
      end else begin
        unique case (ph_c)
          PhRiff, PhRsize, PhWave, PhFmtTag, PhFlen, PhRate, PhCtag, PhDsize,
          PhOsize: begin
            shift_d = gword;
            bif_d   = done4 ? 2'd0 : bif_c + 2'd1;
            if (done4) begin
              unique case (ph_c)
                PhRiff: begin
                  if (gword == TagRiff) ph_d = PhRsize;
                  else begin
                    st_d = StBadTag;
                    ph_d = PhDone;
                  end
                end
                PhRsize: ph_d = PhWave;
                PhWave: begin
                  if (gword == TagWave) ph_d = PhFmtTag;
                  else begin
                    st_d = StBadTag;
                    ph_d = PhDone;
                  end
                end
                PhFmtTag: begin
                  if (gword == TagFmt) ph_d = PhFlen;
                  else begin
                    st_d = StBadTag;
                    ph_d = PhDone;
                  end
                end
                PhFlen: begin
                  flen_d = gword;
                  ph_d   = PhFormat;
                end
                PhRate: begin
                  rate_d = gword;
                  skip_d = GapBytes;
                  ph_d   = PhGap;
                end
                PhCtag: ph_d = (gword == TagData) ? PhDsize : PhOsize;
                PhDsize: begin
                  dlen_d = gword;
                  st_d   = StData;
                  ph_d   = PhDone;
                end
                default: begin
                  // other chunk: skip its body
                  if (gword == 32'd0) ph_d = PhCtag;
                  else begin
                    skip_d = gword;
                    ph_d   = PhCskip;
                  end
                end
              endcase
            end
          end
          PhFormat, PhChan, PhBits: begin
            shift_d = gword;
            bif_d   = done2 ? 2'd0 : bif_c + 2'd1;
            if (done2) begin
              unique case (ph_c)
                PhFormat: begin
                  fmt_d = gword[15:0];
                  ph_d  = PhChan;
                end
                PhChan: begin
                  chan_d = gword[15:0];
                  ph_d   = PhRate;
                end
                default: begin
                  sbytes_d = bits_sh;
                  if (fmt_c == FmtPcm && bits_sh == 13'd1) begin
                    st_d = StPcm8;
                    ph_d = PhDone;
                  end else if (flen_c < FmtMinLen) begin
                    st_d = StShortFmt;
                    ph_d = PhDone;
                  end else if (flen_rest == 32'd0) begin
                    ph_d = PhCtag;
                  end else begin
                    skip_d = flen_rest;
                    ph_d   = PhFskip;
                  end
                end
              endcase
            end
          end
          PhGap: begin
            skip_d = skip_dec;
            if (skip_dec == 32'd0) ph_d = PhBits;
          end
          PhFskip, PhCskip: begin
            skip_d = skip_dec;
            if (skip_dec == 32'd0) ph_d = PhCtag;
          end
          PhDone: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PhRiff;
      bif_q    <= 2'd0;
      skip_q   <= 32'd0;
      shift_q  <= 32'd0;
      fmt_q    <= 16'd0;
      chan_q   <= 16'd0;
      rate_q   <= 32'd0;
      sbytes_q <= 13'd0;
      flen_q   <= 32'd0;
      dlen_q   <= 32'd0;
      st_q     <= StParsing;
    end else if (en_i) begin
      ph_q     <= ph_d;
      bif_q    <= bif_d;
      skip_q   <= skip_d;
      shift_q  <= shift_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      rate_q   <= rate_d;
      sbytes_q <= sbytes_d;
      flen_q   <= flen_d;
      dlen_q   <= dlen_d;
      st_q     <= st_d;
    end
  end

  always_comb begin
    result_o.status        = st_d;
    result_o.format_code   = fmt_d;
    result_o.channel_count = chan_d;
    result_o.rate_hz       = rate_d;
    result_o.sample_bytes  = sbytes_d;
    result_o.data_bytes    = dlen_d;
  end

endmodule

`default_nettype wire

// File: src/wav_header_parser.sv
`default_nettype none

// WAV header parser: takes a WAV file one byte per beat and walks its
// little-endian RIFF header (RIFF / WAVE / fmt tags, format, channels, rate,
// bits per sample, then chunk by chunk up to the data chunk). Every input
// beat gives exactly one result beat carrying the status and all captured
// fields so far; once the status leaves "parsing" the result repeats until a
// beat with restart set. One byte is taken per clock while the result side
// can accept it: a beat lands in an input register, the parser state updates
// as it moves into the result register, and a full result register that is
// being drained does not stall the input, while one that is not drained does.
// Odd chunk sizes are not padded, and a fmt chunk shorter than 16 bytes is
// reported as short fmt rather than re-read.
module wav_header_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,  // [7:0] stream_byte
  input  wire logic [1:0]   s_axis_tuser,  // [0] restart, [1] stream_end
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [2:0] status, [18:3] format_code, [34:19] channel_count,
  // [66:35] rate_hz, [79:67] sample_bytes, [111:80] data_bytes
  output logic [whp_pkg::ResultWidth-1:0] m_axis_tdata
);
  import whp_pkg::*;

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic [1:0] in_user_q;

  // result register
  logic    out_vld_q, out_vld_d;
  result_t out_q;
  result_t core_res;

  logic in_acc;
  logic adv;  // input register beat moves into the result register

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_acc ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign out_vld_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  whp_parse_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .stream_byte_i (in_byte_q),
    .restart_i     (in_user_q[0]),
    .stream_end_i  (in_user_q[1]),
    .result_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
    if (adv) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
